FILE: hdl/icmpprc_pkg.sv
// Shared types and constants for the ICMP probe reply classifier.
`default_nettype none

package icmpprc_pkg;

  localparam int unsigned POS_W = 11;
  localparam int unsigned LEN_W = POS_W + 1;

  localparam logic [POS_W-1:0] POS_LIMIT      = 11'd2047;
  localparam logic [3:0]       HDR_NIBBLE     = 4'hF;
  localparam logic [3:0]       ICMP_HDR_BYTES = 4'd8;
  localparam logic [3:0]       INNER_PROTO_OFS = 4'd9;
  localparam logic [7:0]       PROTO_UDP      = 8'd17;

  localparam logic [7:0] ICMP_TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] ICMP_UNREACHABLE        = 8'd3;
  localparam logic [7:0] ICMP_TYPE_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] CODE_PORT_UNREACH  = 8'd3;
  localparam logic [7:0] CODE_TTL_TRANSIT   = 8'd0;

  localparam logic [1:0] VERDICT_DONE  = 2'd0;
  localparam logic [1:0] VERDICT_HOP   = 2'd1;
  localparam logic [1:0] VERDICT_ERROR = 2'd2;
  localparam logic [1:0] VERDICT_OTHER = 2'd3;

  localparam logic [1:0] REG_UDP_MODE   = 2'd0;
  localparam logic [1:0] REG_LOCAL_PORT = 2'd1;
  localparam logic [1:0] REG_DEST_PORT  = 2'd2;
  localparam logic [1:0] REG_PROBE_ID   = 2'd3;

  // fields_seen: bit 0 inner protocol, 1 source port, 2 destination port, 3 ICMP id
  typedef struct packed {
    logic [5:0]  outer_header_length;
    logic [15:0] total_length;
    logic [7:0]  message_type;
    logic [7:0]  message_code;
    logic [15:0] message_identifier;
    logic [5:0]  inner_header_length;
    logic [7:0]  inner_protocol;
    logic [15:0] inner_source_port;
    logic [15:0] inner_dest_port;
    logic [15:0] inner_message_identifier;
    logic [3:0]  fields_seen;
  } pkt_fields_t;

endpackage

`default_nettype wire

FILE: hdl/icmpprc_capture.sv
// Byte position tracking and header field capture for one packet.
`default_nettype none

module icmpprc_capture
  import icmpprc_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  output pkt_fields_t            fields_next,
  output logic [LEN_W-1:0]       rx_length
);

  localparam int unsigned CMP_W = 17;

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  pkt_fields_t      fields;
  logic [POS_W-1:0] ic;
  logic [POS_W-1:0] inner;
  logic [POS_W-1:0] d;
  logic [LEN_W-1:0] pos_plus;

  always_comb begin
    fields_next = fields;
    ic          = '0;
    inner       = '0;
    d           = '0;
    if (CMP_W'(byte_position) < CMP_W'(MAX_PACKET_BYTES)) begin
      if (byte_position == '0)
        fields_next.outer_header_length = {data_byte[3:0] & HDR_NIBBLE, 2'b00};
      if (byte_position == POS_W'(2)) fields_next.total_length[15:8] = data_byte;
      if (byte_position == POS_W'(3)) fields_next.total_length[7:0]  = data_byte;
      // offsets follow the header length as already updated by this byte
      ic = POS_W'(fields_next.outer_header_length);
      if (byte_position == ic)              fields_next.message_type = data_byte;
      if (byte_position == ic + POS_W'(1))  fields_next.message_code = data_byte;
      if (byte_position == ic + POS_W'(4))  fields_next.message_identifier[15:8] = data_byte;
      if (byte_position == ic + POS_W'(5))  fields_next.message_identifier[7:0]  = data_byte;
      inner = ic + POS_W'(ICMP_HDR_BYTES);
      if (byte_position == inner)
        fields_next.inner_header_length = {data_byte[3:0] & HDR_NIBBLE, 2'b00};
      if (byte_position == inner + POS_W'(INNER_PROTO_OFS)) begin
        fields_next.inner_protocol = data_byte;
        fields_next.fields_seen[0] = 1'b1;
      end
      d = inner + POS_W'(fields_next.inner_header_length);
      if (byte_position == d) fields_next.inner_source_port[15:8] = data_byte;
      if (byte_position == d + POS_W'(1)) begin
        fields_next.inner_source_port[7:0] = data_byte;
        fields_next.fields_seen[1] = 1'b1;
      end
      if (byte_position == d + POS_W'(2)) fields_next.inner_dest_port[15:8] = data_byte;
      if (byte_position == d + POS_W'(3)) begin
        fields_next.inner_dest_port[7:0] = data_byte;
        fields_next.fields_seen[2] = 1'b1;
      end
      if (byte_position == d + POS_W'(4))
        fields_next.inner_message_identifier[15:8] = data_byte;
      if (byte_position == d + POS_W'(5)) begin
        fields_next.inner_message_identifier[7:0] = data_byte;
        fields_next.fields_seen[3] = 1'b1;
      end
    end
  end

  // received length, capped at the buffer size
  always_comb begin
    pos_plus = LEN_W'(byte_position) + LEN_W'(1);
    if (CMP_W'(pos_plus) > CMP_W'(MAX_PACKET_BYTES))
      rx_length = LEN_W'(MAX_PACKET_BYTES);
    else
      rx_length = pos_plus;
  end

  assign byte_position_next = (byte_position < POS_LIMIT) ? byte_position + POS_W'(1)
                                                          : byte_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      fields        <= '0;
    end else if (accept) begin
      if (last_byte) begin
        // clear for the next packet
        byte_position <= '0;
        fields        <= '0;
      end else begin
        byte_position <= byte_position_next;
        fields        <= fields_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/icmp_probe_reply_classifier_top.sv
// Top level of the ICMP probe reply classifier: config, verdict and result register.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall  data_byte, last_byte
//   out       source     out_valid / out_stall verdict, icmp_type_seen
//   cfg       sink       cfg_wr_en            cfg_index, cfg_data
//
// One word is taken per cycle while in_stall is low; the verdict appears in the result
// register in the cycle after the last byte is taken, set by the single capture/compare stage.
// Reset clears the packet state, the config registers and the result valid.
// in_stall rises only while a result waits and out_stall holds it.
`default_nettype none

module icmp_probe_reply_classifier_top
  import icmpprc_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       verdict,
  output logic [7:0]       icmp_type_seen,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic             udp_mode;
  logic [15:0]      local_source_port;
  logic [15:0]      expected_dest_port;
  logic [15:0]      probe_id;
  logic             accept;
  pkt_fields_t      fn;
  logic [LEN_W-1:0] rx_length;
  logic             udp_match;
  logic [15:0]      body_length;
  logic [1:0]       verdict_next;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  icmpprc_capture #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_capture (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .fields_next(fn),
    .rx_length  (rx_length)
  );

  always_comb begin
    udp_match = (fn.fields_seen[2:0] == 3'b111) && (fn.inner_protocol == PROTO_UDP) &&
                (fn.inner_dest_port == expected_dest_port) &&
                (fn.inner_source_port == local_source_port);
    body_length  = fn.total_length - 16'(fn.outer_header_length);
    verdict_next = VERDICT_OTHER;
    if (rx_length < LEN_W'(fn.outer_header_length) + LEN_W'(ICMP_HDR_BYTES)) begin
      verdict_next = VERDICT_ERROR;
    end else if (body_length < 16'(fn.inner_header_length) + 16'(ICMP_HDR_BYTES)
                               + 16'(ICMP_HDR_BYTES)) begin
      verdict_next = VERDICT_ERROR;
    end else if (fn.message_type == ICMP_TYPE_ECHO_REPLY) begin
      if (fn.message_identifier == probe_id) verdict_next = VERDICT_DONE;
    end else if (fn.message_type == ICMP_UNREACHABLE) begin
      if (udp_match && fn.message_code == CODE_PORT_UNREACH) verdict_next = VERDICT_DONE;
    end else if (fn.message_type == ICMP_TYPE_TIME_EXCEEDED &&
                 fn.message_code == CODE_TTL_TRANSIT) begin
      if (udp_mode) begin
        if (udp_match) verdict_next = VERDICT_HOP;
      end else if (fn.fields_seen[3] && fn.inner_message_identifier == probe_id) begin
        verdict_next = VERDICT_HOP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      udp_mode           <= 1'b0;
      local_source_port  <= '0;
      expected_dest_port <= '0;
      probe_id           <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_UDP_MODE:   udp_mode           <= cfg_data[0];
        REG_LOCAL_PORT: local_source_port  <= cfg_data;
        REG_DEST_PORT:  expected_dest_port <= cfg_data;
        REG_PROBE_ID:   probe_id           <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // load the result word on the last byte, hold it otherwise
  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      verdict        <= verdict_next;
      icmp_type_seen <= fn.message_type;
    end
  end

endmodule

`default_nettype wire

FILE: dv/icmp_probe_reply_classifier_top_test.sv
// Self-checking testbench for the ICMP probe reply classifier top level.
`timescale 1ns / 1ps

module icmp_probe_reply_classifier_top_test
  import icmpprc_pkg::*;
();

  localparam int PKT_BUF_BYTES = 1024;
  localparam int HOLD_CYCLES   = 150;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_BYTES   = 48;
  localparam int RAND_BYTES    = 288;
  localparam int RAND_REPLIES  = 6;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [7:0] msg_type;
  } verdict_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  verdict;
  logic [7:0]  icmp_type_seen;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_UDP_MODE;
  logic [15:0] cfg_data = 16'd0;

  icmp_probe_reply_classifier_top #(
    .MAX_PACKET_BYTES(PKT_BUF_BYTES)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .verdict       (verdict),
    .icmp_type_seen(icmp_type_seen),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  byte_word_t    byte_q[$];
  verdict_word_t verdict_q[$];
  logic [7:0]    frame[$];

  // register mirrors and packet capture state of the classifier
  logic        cfg_udp_mode;
  logic [15:0] cfg_local_port;
  logic [15:0] cfg_dest_port;
  logic [15:0] cfg_probe_id;
  pkt_fields_t pkt;
  logic [10:0] pkt_pos;

  logic in_took = 1'b0;
  bit   tx_pause = 1'b0;
  int   idle_pct = 10;
  int   hold_asks = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  int   errors = 0;
  int   cycle_count = 0;
  int   bytes_sent = 0;
  int   replies_sent = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void clear_capture();
    pkt = '0;
    pkt_pos = '0;
  endfunction

  function automatic logic [1:0] judge_reply(input int len);
    logic [15:0] body_length;
    bit          ports_ok;
    if (len < int'(pkt.outer_header_length) + 8) return VERDICT_ERROR;
    body_length = pkt.total_length - 16'(pkt.outer_header_length);
    if (int'(body_length) < 16 + int'(pkt.inner_header_length)) return VERDICT_ERROR;
    ports_ok = (pkt.fields_seen[2:0] == 3'b111) && (pkt.inner_protocol == PROTO_UDP) &&
               (pkt.inner_dest_port == cfg_dest_port) &&
               (pkt.inner_source_port == cfg_local_port);
    case (pkt.message_type)
      ICMP_TYPE_ECHO_REPLY: begin
        if (pkt.message_identifier == cfg_probe_id) return VERDICT_DONE;
      end
      ICMP_UNREACHABLE: begin
        if (ports_ok && pkt.message_code == CODE_PORT_UNREACH) return VERDICT_DONE;
      end
      ICMP_TYPE_TIME_EXCEEDED: begin
        if (pkt.message_code == CODE_TTL_TRANSIT) begin
          if (cfg_udp_mode) begin
            if (ports_ok) return VERDICT_HOP;
          end else if (pkt.fields_seen[3] && pkt.inner_message_identifier == cfg_probe_id) begin
            return VERDICT_HOP;
          end
        end
      end
      default: ;
    endcase
    return VERDICT_OTHER;
  endfunction

  // Capture one byte at its offset; on the last byte give the verdict and clear.
  function automatic void absorb_byte(input logic [7:0] b, input logic is_last,
                                      output bit got, output verdict_word_t res);
    int idx, ic, inner, d, len;
    idx = int'(pkt_pos);
    got = 1'b0;
    res = '0;
    if (idx < PKT_BUF_BYTES) begin
      if (idx == 0) pkt.outer_header_length = {b[3:0], 2'b00};
      if (idx == 2) pkt.total_length[15:8] = b;
      if (idx == 3) pkt.total_length[7:0] = b;
      ic = int'(pkt.outer_header_length);
      if (idx == ic) pkt.message_type = b;
      if (idx == ic + 1) pkt.message_code = b;
      if (idx == ic + 4) pkt.message_identifier[15:8] = b;
      if (idx == ic + 5) pkt.message_identifier[7:0] = b;
      inner = ic + 8;
      if (idx == inner) pkt.inner_header_length = {b[3:0], 2'b00};
      if (idx == inner + 9) begin
        pkt.inner_protocol = b;
        pkt.fields_seen[0] = 1'b1;
      end
      d = inner + int'(pkt.inner_header_length);
      if (idx == d) pkt.inner_source_port[15:8] = b;
      if (idx == d + 1) begin
        pkt.inner_source_port[7:0] = b;
        pkt.fields_seen[1] = 1'b1;
      end
      if (idx == d + 2) pkt.inner_dest_port[15:8] = b;
      if (idx == d + 3) begin
        pkt.inner_dest_port[7:0] = b;
        pkt.fields_seen[2] = 1'b1;
      end
      if (idx == d + 4) pkt.inner_message_identifier[15:8] = b;
      if (idx == d + 5) begin
        pkt.inner_message_identifier[7:0] = b;
        pkt.fields_seen[3] = 1'b1;
      end
    end
    if (pkt_pos != POS_LIMIT) pkt_pos = pkt_pos + 11'd1;
    if (is_last) begin
      len = (idx + 1 > PKT_BUF_BYTES) ? PKT_BUF_BYTES : idx + 1;
      res.verdict = judge_reply(len);
      res.msg_type = pkt.message_type;
      got = 1'b1;
      clear_capture();
    end
  endfunction

  // Monitor: mirror register writes, check verdicts, predict from accepted bytes.
  always @(posedge clk) begin : watch_ports
    bit            got;
    verdict_word_t res;
    verdict_word_t want;
    if (rst) begin
      in_took = 1'b0;
      cfg_udp_mode = 1'b0;
      cfg_local_port = '0;
      cfg_dest_port = '0;
      cfg_probe_id = '0;
      clear_capture();
    end else if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d verdicts outstanding", $time, verdict_q.size());
      $display("icmp_probe_reply_classifier_top regression: fail");
      $finish;
    end else begin
      cycle_count++;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_UDP_MODE:   cfg_udp_mode = cfg_data[0];
          REG_LOCAL_PORT: cfg_local_port = cfg_data;
          REG_DEST_PORT:  cfg_dest_port = cfg_data;
          REG_PROBE_ID:   cfg_probe_id = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: verdict %0d type %0d", $time, verdict,
                   icmp_type_seen);
        end else begin
          want = verdict_q.pop_front();
          if (verdict !== want.verdict) begin
            errors++;
            $display("%0t: verdict expected %0d got %0d", $time, want.verdict, verdict);
          end
          if (icmp_type_seen !== want.msg_type) begin
            errors++;
            $display("%0t: icmp_type_seen expected %0d got %0d", $time, want.msg_type,
                     icmp_type_seen);
          end
        end
      end
      in_took = in_valid && !in_stall;
      if (in_took) begin
        absorb_byte(data_byte, last_byte, got, res);
        if (got) verdict_q.push_back(res);
      end
    end
  end

  // Driver: hold a word until taken, then offer the next one or idle.
  always @(negedge clk) begin : drive_bytes
    byte_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (byte_q.size() != 0 && !tx_pause && $urandom_range(99) >= idle_pct) begin
        w = byte_q.pop_front();
        data_byte <= w.data;
        last_byte <= w.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_stall
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_config(input logic mode, input logic [15:0] lport, input logic [15:0] dport,
                            input logic [15:0] pid);
    logic [15:0] m;
    m = 16'($urandom);
    m[0] = mode;
    write_reg(REG_UDP_MODE, m);
    write_reg(REG_LOCAL_PORT, lport);
    write_reg(REG_DEST_PORT, dport);
    write_reg(REG_PROBE_ID, pid);
  endtask

  // Queue the first keep bytes of the frame (all of it when keep is zero).
  task automatic ship_frame(input int keep);
    int n;
    n = (keep > 0 && keep < frame.size()) ? keep : frame.size();
    for (int i = 0; i < n; i++) byte_q.push_back({frame[i], i == n - 1});
    bytes_sent += n;
    replies_sent++;
  endtask

  task automatic queue_noise(input int len, input int fill);
    frame.delete();
    for (int i = 0; i < len; i++) frame.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    ship_frame(0);
  endtask

  // Build an IPv4 packet carrying an ICMP message that quotes a probe header.
  // spoil: bit 0 breaks the source port, bit 1 the destination port, bit 2 the id.
  task automatic queue_reply(input logic [7:0] otype, input logic [7:0] ocode, input int ohl,
                             input int ihl, input bit inner_udp, input logic [2:0] spoil,
                             input int pad, input int cut, input int tl_delta);
    logic [15:0] sport, dport, ident, tl;
    int          base;
    sport = cfg_local_port;
    dport = cfg_dest_port;
    ident = cfg_probe_id;
    if (spoil[0]) sport ^= 16'd1 << $urandom_range(15);
    if (spoil[1]) dport ^= 16'd1 << $urandom_range(15);
    if (spoil[2]) ident ^= 16'd1 << $urandom_range(15);
    frame.delete();
    for (int i = 0; i < ohl * 4; i++) frame.push_back(8'($urandom));
    if (ohl > 0) frame[0] = {4'h4, 4'(ohl)};
    frame.push_back(otype);
    frame.push_back(ocode);
    frame.push_back(8'($urandom));
    frame.push_back(8'($urandom));
    frame.push_back(ident[15:8]);
    frame.push_back(ident[7:0]);
    frame.push_back(8'($urandom));
    frame.push_back(8'($urandom));
    base = frame.size();
    for (int i = 0; i < ihl * 4; i++) frame.push_back(8'($urandom));
    if (ihl > 0) frame[base] = {4'h4, 4'(ihl)};
    if (ihl * 4 > 9) frame[base + 9] = inner_udp ? PROTO_UDP : 8'd1;
    if (inner_udp) begin
      frame.push_back(sport[15:8]);
      frame.push_back(sport[7:0]);
      frame.push_back(dport[15:8]);
      frame.push_back(dport[7:0]);
    end else begin
      frame.push_back(8'd8);
      frame.push_back(8'd0);
      frame.push_back(8'($urandom));
      frame.push_back(8'($urandom));
    end
    frame.push_back(inner_udp ? 8'($urandom) : ident[15:8]);
    frame.push_back(inner_udp ? 8'($urandom) : ident[7:0]);
    frame.push_back(8'($urandom));
    frame.push_back(8'($urandom));
    for (int i = 0; i < pad; i++) frame.push_back(8'($urandom));
    tl = 16'(frame.size() + tl_delta);
    if (ohl > 0) begin
      frame[2] = tl[15:8];
      frame[3] = tl[7:0];
    end
    ship_frame(cut);
  endtask

  task automatic queue_random_packet();
    logic [7:0] t, c;
    logic [2:0] spoil;
    int         r, ohl, ihl, pad, cut, delta;
    bit         udp;
    if ($urandom_range(99) < 10) begin
      queue_noise($urandom_range(1, 40), -1);
    end else begin
      r = $urandom_range(99);
      t = (r < 30) ? ICMP_TYPE_ECHO_REPLY : (r < 60) ? ICMP_UNREACHABLE :
          (r < 90) ? ICMP_TYPE_TIME_EXCEEDED : 8'($urandom);
      if (t == ICMP_UNREACHABLE)
        c = ($urandom_range(3) == 0) ? 8'($urandom) : CODE_PORT_UNREACH;
      else if (t == ICMP_TYPE_TIME_EXCEEDED)
        c = ($urandom_range(3) == 0) ? 8'($urandom) : CODE_TTL_TRANSIT;
      else
        c = ($urandom_range(9) == 0) ? 8'($urandom) : 8'd0;
      ohl = ($urandom_range(4) == 0) ? $urandom_range(15) : 5;
      ihl = ($urandom_range(4) == 0) ? $urandom_range(15) : 5;
      if (t == ICMP_UNREACHABLE || cfg_udp_mode) udp = ($urandom_range(7) != 0);
      else udp = ($urandom_range(7) == 0);
      spoil = ($urandom_range(3) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
      pad = ($urandom_range(3) == 0) ? $urandom_range(1, 24) : 0;
      cut = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : 0;
      delta = ($urandom_range(9) == 0) ? int'($urandom_range(65535)) - 40 : 0;
      queue_reply(t, c, ohl, ihl, udp, spoil, pad, cut, delta);
    end
  endtask

  // Wait until every queued word is taken and every verdict is back, then settle.
  task automatic drain();
    while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : run_test
    int ph, start, half, rand_bytes0, rand_replies0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // registers at reset: ICMP mode, ports and id all zero
    queue_reply(ICMP_TYPE_ECHO_REPLY, 8'd0, 5, 5, 1'b0, 3'b000, 0, 0, 0);
    queue_reply(ICMP_TYPE_ECHO_REPLY, 8'd0, 5, 5, 1'b0, 3'b100, 0, 0, 0);
    queue_noise(1, -1);
    queue_reply(ICMP_TYPE_TIME_EXCEEDED, CODE_TTL_TRANSIT, 5, 5, 1'b0, 3'b000, 0, 0, 0);
    queue_reply(ICMP_TYPE_TIME_EXCEEDED, 8'd1, 5, 5, 1'b0, 3'b000, 0, 0, 0);
    queue_reply(ICMP_UNREACHABLE, CODE_PORT_UNREACH, 5, 5, 1'b1, 3'b000, 0, 0, 0);
    drain();

    set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_reply(ICMP_UNREACHABLE, CODE_PORT_UNREACH, 5, 5, 1'b1, 3'b000, 4, 0, 0);
    queue_reply(ICMP_UNREACHABLE, 8'd1, 5, 5, 1'b1, 3'b000, 0, 0, 0);
    queue_reply(ICMP_UNREACHABLE, CODE_PORT_UNREACH, 5, 5, 1'b1, 3'b001, 0, 0, 0);
    queue_reply(ICMP_UNREACHABLE, CODE_PORT_UNREACH, 5, 5, 1'b1, 3'b010, 0, 0, 0);
    queue_reply(ICMP_TYPE_TIME_EXCEEDED, CODE_TTL_TRANSIT, 5, 5, 1'b1, 3'b000, 0, 0, 0);
    queue_reply(ICMP_TYPE_TIME_EXCEEDED, CODE_TTL_TRANSIT, 5, 5, 1'b0, 3'b000, 0, 0, 0);
    // header length zero: fields share bytes
    queue_reply(ICMP_TYPE_ECHO_REPLY, 8'd0, 0, 0, 1'b0, 3'b000, 8, 0, 0);
    queue_reply(ICMP_TYPE_TIME_EXCEEDED, CODE_TTL_TRANSIT, 15, 15, 1'b1, 3'b000, 0, 0, 0);
    // cut before the quoted ports: inner fields never reached
    queue_reply(ICMP_TYPE_TIME_EXCEEDED, CODE_TTL_TRANSIT, 5, 5, 1'b1, 3'b000, 0, 40, 0);
    queue_reply(ICMP_TYPE_ECHO_REPLY, 8'd0, 5, 5, 1'b0, 3'b000, 0, 27, 0);
    // total length too small for the ICMP body, and wrapping below the header
    queue_reply(ICMP_TYPE_ECHO_REPLY, 8'd0, 5, 5, 1'b0, 3'b000, 0, 0, -30);
    queue_reply(ICMP_TYPE_ECHO_REPLY, 8'd0, 5, 5, 1'b0, 3'b000, 0, 0, -60);
    drain();

    rand_bytes0 = bytes_sent;
    rand_replies0 = replies_sent;
    ph = 0;
    while (ph < 6 || bytes_sent - rand_bytes0 < RAND_BYTES ||
           replies_sent - rand_replies0 < RAND_REPLIES) begin
      if (ph == 0) set_config(1'b0, 16'h0000, 16'h0000, 16'h0000);
      else if (ph == 1) set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      else set_config(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      idle_pct = (ph == 2) ? 0 : 10;
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) queue_random_packet();
      // hold the result side off while bytes keep coming
      if (ph == 3) hold_asks++;
      if (ph == 4) begin
        half = byte_q.size() / 2;
        while (byte_q.size() > half) @(posedge clk);
        tx_pause = 1'b1;
        while (in_valid || verdict_q.size() != 0) @(posedge clk);
        tx_pause = 1'b0;
      end
      drain();
      ph++;
    end

    if (errors == 0) begin
      $display("icmp_probe_reply_classifier_top regression: pass");
    end else begin
      $display("icmp_probe_reply_classifier_top regression: fail");
    end
    $finish;
  end

endmodule
